// ===== src/cmas_pkg.sv =====
// Shared constants, types and helpers for the centered moving average path smoother.
// Used by cmas_div and centered_moving_average_path_smoother_unit; no dependencies.
package cmas_pkg;

	// Path point shape and window limits.
	localparam int MAX_HALF    = 16;
	localparam int FIELD_COUNT = 10;
	localparam int DATA_W      = 32;
	localparam int HW_W        = 5;
	localparam int HW_RESET    = 5;

	// Ring of the last 2*MAX_HALF+1 points, one field per memory word.
	localparam int RING_DEPTH = 2 * MAX_HALF + 1;
	localparam int RAM_DEPTH  = RING_DEPTH * FIELD_COUNT;
	localparam int ADDR_W     = $clog2(RAM_DEPTH);
	localparam int SLOT_W     = $clog2(RING_DEPTH);
	localparam int CNT_W      = $clog2(RING_DEPTH + 1);
	localparam int K_W        = $clog2(MAX_HALF + 1);
	localparam int FIELD_W    = (FIELD_COUNT > 1) ? $clog2(FIELD_COUNT) : 1;

	// Window sum and the iterative divider that turns it into a mean.
	localparam int SUM_W          = DATA_W + CNT_W;
	localparam int DIV_RADIX_BITS = 4;
	localparam int DIV_W          = ((SUM_W + DIV_RADIX_BITS - 1) / DIV_RADIX_BITS)
		* DIV_RADIX_BITS;
	localparam int DIV_CYCLES     = DIV_W / DIV_RADIX_BITS;
	localparam int DIV_CNT_W      = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;
	localparam int REM_W          = CNT_W + 1;

	// Configuration port.
	localparam int PADDR_W   = 3;
	localparam int REG_IDX_W = PADDR_W - 2;
	localparam logic [REG_IDX_W-1:0] REG_HALF_WINDOW = REG_IDX_W'(0);

	typedef logic signed [DATA_W-1:0] word_t;
	typedef logic [SLOT_W:0] slot_ext_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WRITE,
		ST_DECIDE,
		ST_SUM,
		ST_DIV,
		ST_OUT
	} ctl_state_t;

	// Divider request and response.
	typedef struct packed {
		logic                    start;
		logic signed [SUM_W-1:0] dividend;
		logic [CNT_W-1:0]        divisor;
	} div_cmd_t;

	typedef struct packed {
		logic  done;
		word_t quotient;
	} div_rsp_t;

	// Memory word address of one field of one ring slot.
	function automatic logic [ADDR_W-1:0] ram_addr(input logic [SLOT_W-1:0] slot,
		input logic [FIELD_W-1:0] field);
		return ADDR_W'(slot) * ADDR_W'(FIELD_COUNT) + ADDR_W'(field);
	endfunction

endpackage

// ===== src/centered_moving_average_path_smoother_unit.sv =====
// Centered moving average smoother for a stream of path points; top level.
// Depends on cmas_pkg, cmas_ram and cmas_div.
//
// Usage: path points arrive on the in_valid/in_ready channel, one request per point,
// with last_in marking the final point. Smoothed points leave on out_valid/out_ready
// in path order. The half width is written over the APB port at byte address 0 and
// is taken at the first point of each path; values above 16 act as 16.
// A point is written into the ring field by field, then each result it releases is
// built field by field: a window of 2n+1 words is summed through one adder and
// the sum goes through the shared divider, n being the result's window half width.
// The final point releases all remaining results.
// in_ready is high only while the sequencer is idle.
// The output register holds a finished result while the receiver stalls; the
// sequencer builds the next result meanwhile and waits only to hand it over.
// Reset clears the path state and sets the half width to 5; the ring memory needs
// no clearing pass, as only points of the current path are read.
module centered_moving_average_path_smoother_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	// Configuration port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [cmas_pkg::PADDR_W-1:0]  paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	// Input channel
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [31:0]            pos_x,
	input  logic signed [31:0]            pos_y,
	input  logic signed [31:0]            pos_z,
	input  logic signed [31:0]            heading,
	input  logic signed [31:0]            speed_long,
	input  logic signed [31:0]            accel,
	input  logic signed [31:0]            front_angle,
	input  logic signed [31:0]            yaw_rate,
	input  logic signed [31:0]            speed_lat,
	input  logic signed [31:0]            rear_angle,
	input  logic                          last_in,
	// Output channel
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [31:0]            avg_x,
	output logic signed [31:0]            avg_y,
	output logic signed [31:0]            avg_z,
	output logic signed [31:0]            avg_heading,
	output logic signed [31:0]            avg_speed_long,
	output logic signed [31:0]            avg_accel,
	output logic signed [31:0]            avg_front_angle,
	output logic signed [31:0]            avg_yaw_rate,
	output logic signed [31:0]            avg_speed_lat,
	output logic signed [31:0]            avg_rear_angle,
	output logic                          last_out,
	output logic                          smoothed
);

	cmas_pkg::ctl_state_t state_q, state_d;

	logic [cmas_pkg::HW_W-1:0]    hw_q;
	cmas_pkg::word_t              in_q [cmas_pkg::FIELD_COUNT];
	logic                         last_q;
	logic [cmas_pkg::FIELD_W-1:0] field_q;
	logic [cmas_pkg::SLOT_W-1:0]  wr_ptr_q;
	logic [cmas_pkg::CNT_W-1:0]   seen_q;
	logic [cmas_pkg::CNT_W-1:0]   pending_q;
	logic [cmas_pkg::K_W-1:0]     emitted_q;
	logic [cmas_pkg::K_W-1:0]     k_act_q;
	logic                         started_q;
	logic                         sm_q;
	logic [cmas_pkg::CNT_W-1:0]   cnt_q;
	logic [cmas_pkg::CNT_W-1:0]   issue_q;
	logic [cmas_pkg::SLOT_W-1:0]  start_slot_q;
	logic [cmas_pkg::SLOT_W-1:0]  slot_q;
	logic                         rd_valid_s1;
	logic signed [cmas_pkg::SUM_W-1:0] acc_q;
	cmas_pkg::word_t              res_q [cmas_pkg::FIELD_COUNT];
	cmas_pkg::word_t              out_q [cmas_pkg::FIELD_COUNT];
	logic                         out_valid_q;
	logic                         out_last_q;
	logic                         out_sm_q;

	logic                         cfg_wr;
	logic [cmas_pkg::REG_IDX_W-1:0] reg_idx;
	logic [cmas_pkg::K_W-1:0]     k_new;
	logic                         accept;
	logic                         field_last;
	logic [cmas_pkg::CNT_W-1:0]   seen_inc;
	logic [cmas_pkg::CNT_W-1:0]   after;
	logic [cmas_pkg::K_W-1:0]     emit_lim;
	logic                         dec_emit;
	logic [cmas_pkg::K_W-1:0]     dec_num;
	logic                         dec_sm;
	logic [cmas_pkg::CNT_W-1:0]   back;
	cmas_pkg::slot_ext_t          slot_tmp;
	logic [cmas_pkg::SLOT_W-1:0]  dec_slot;
	logic                         issue_go;
	logic                         sum_done;
	logic                         out_free;
	logic                         out_load;
	logic                         ram_we;
	logic [cmas_pkg::ADDR_W-1:0]  ram_waddr;
	logic [cmas_pkg::ADDR_W-1:0]  ram_raddr;
	cmas_pkg::word_t              ram_wdata;
	logic [cmas_pkg::DATA_W-1:0]  ram_rdata;
	cmas_pkg::div_cmd_t           div_cmd;
	cmas_pkg::div_rsp_t           div_rsp;

	// Configuration register.
	assign reg_idx = paddr[cmas_pkg::PADDR_W-1:2];
	assign cfg_wr  = psel && penable && pwrite;
	assign pready  = 1'b1;
	assign prdata  = (reg_idx == cmas_pkg::REG_HALF_WINDOW) ? 32'(hw_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hw_q <= cmas_pkg::HW_W'(cmas_pkg::HW_RESET);
		end else if (cfg_wr && (reg_idx == cmas_pkg::REG_HALF_WINDOW)) begin
			hw_q <= pwdata[cmas_pkg::HW_W-1:0];
		end
	end

	// Half width clamped to the ring's reach.
	assign k_new = (hw_q > cmas_pkg::HW_W'(cmas_pkg::MAX_HALF))
		? cmas_pkg::K_W'(cmas_pkg::MAX_HALF) : cmas_pkg::K_W'(hw_q);

	assign accept     = in_valid && in_ready;
	assign field_last = (field_q == cmas_pkg::FIELD_W'(cmas_pkg::FIELD_COUNT - 1));
	assign seen_inc   = (seen_q == cmas_pkg::CNT_W'(cmas_pkg::RING_DEPTH))
		? seen_q : seen_q + 1'b1;

	// Decide whether the oldest pending point can be answered now, and over which window.
	assign after    = pending_q - 1'b1;
	assign emit_lim = (emitted_q < k_act_q) ? emitted_q : k_act_q;

	always_comb begin
		dec_emit = 1'b0;
		dec_num  = emit_lim;
		dec_sm   = 1'b1;
		if (pending_q != '0) begin
			if (started_q) begin
				if (after < cmas_pkg::CNT_W'(emit_lim)) begin
					if (last_q) begin
						dec_emit = 1'b1;
						dec_num  = cmas_pkg::K_W'(after);
					end
				end else begin
					dec_emit = 1'b1;
				end
			end else if (last_q) begin
				dec_emit = 1'b1;
				dec_num  = '0;
				dec_sm   = 1'b0;
			end
		end
	end

	// Ring slot of the oldest point in the window.
	always_comb begin
		back     = after + cmas_pkg::CNT_W'(dec_num);
		slot_tmp = cmas_pkg::slot_ext_t'(wr_ptr_q)
			+ cmas_pkg::slot_ext_t'(cmas_pkg::RING_DEPTH - 1)
			- cmas_pkg::slot_ext_t'(back);
		if (slot_tmp >= cmas_pkg::slot_ext_t'(cmas_pkg::RING_DEPTH)) begin
			slot_tmp = slot_tmp - cmas_pkg::slot_ext_t'(cmas_pkg::RING_DEPTH);
		end
		dec_slot = slot_tmp[cmas_pkg::SLOT_W-1:0];
	end

	assign issue_go = (state_q == cmas_pkg::ST_SUM) && (issue_q != cnt_q);
	assign sum_done = (state_q == cmas_pkg::ST_SUM) && (issue_q == cnt_q) && !rd_valid_s1;
	assign out_free = !out_valid_q || out_ready;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			cmas_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = cmas_pkg::ST_WRITE;
				end
			end
			cmas_pkg::ST_WRITE: begin
				if (field_last) begin
					state_d = cmas_pkg::ST_DECIDE;
				end
			end
			cmas_pkg::ST_DECIDE: begin
				state_d = dec_emit ? cmas_pkg::ST_SUM : cmas_pkg::ST_IDLE;
			end
			cmas_pkg::ST_SUM: begin
				if (sum_done) begin
					state_d = cmas_pkg::ST_DIV;
				end
			end
			cmas_pkg::ST_DIV: begin
				if (div_rsp.done) begin
					state_d = field_last ? cmas_pkg::ST_OUT : cmas_pkg::ST_SUM;
				end
			end
			cmas_pkg::ST_OUT: begin
				if (out_free) begin
					state_d = cmas_pkg::ST_DECIDE;
				end
			end
			default: begin
				state_d = cmas_pkg::ST_IDLE;
			end
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		in_ready         = (state_q == cmas_pkg::ST_IDLE);
		ram_we           = (state_q == cmas_pkg::ST_WRITE);
		ram_waddr        = cmas_pkg::ram_addr(wr_ptr_q, field_q);
		ram_wdata        = in_q[field_q];
		ram_raddr        = cmas_pkg::ram_addr(slot_q, field_q);
		div_cmd.start    = sum_done;
		div_cmd.dividend = acc_q;
		div_cmd.divisor  = cnt_q;
		out_load         = (state_q == cmas_pkg::ST_OUT) && out_free;
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= cmas_pkg::ST_IDLE;
			field_q      <= '0;
			wr_ptr_q     <= '0;
			seen_q       <= '0;
			pending_q    <= '0;
			emitted_q    <= '0;
			k_act_q      <= '0;
			started_q    <= 1'b0;
			sm_q         <= 1'b0;
			cnt_q        <= '0;
			issue_q      <= '0;
			start_slot_q <= '0;
			slot_q       <= '0;
			rd_valid_s1  <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q     <= state_d;
			rd_valid_s1 <= issue_go;

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				cmas_pkg::ST_IDLE: begin
					if (accept) begin
						field_q <= '0;
						if (seen_q == '0) begin
							k_act_q   <= k_new;
							started_q <= 1'b0;
						end
					end
				end
				cmas_pkg::ST_WRITE: begin
					if (field_last) begin
						field_q  <= '0;
						wr_ptr_q <= (wr_ptr_q == cmas_pkg::SLOT_W'(cmas_pkg::RING_DEPTH - 1))
							? '0 : wr_ptr_q + 1'b1;
						seen_q   <= seen_inc;
						if (pending_q != cmas_pkg::CNT_W'(cmas_pkg::RING_DEPTH)) begin
							pending_q <= pending_q + 1'b1;
						end
						if (seen_inc >= cmas_pkg::CNT_W'({k_act_q, 1'b1})) begin
							started_q <= 1'b1;
						end
					end else begin
						field_q <= field_q + 1'b1;
					end
				end
				cmas_pkg::ST_DECIDE: begin
					if (dec_emit) begin
						sm_q         <= dec_sm;
						cnt_q        <= cmas_pkg::CNT_W'({dec_num, 1'b1});
						start_slot_q <= dec_slot;
						slot_q       <= dec_slot;
						issue_q      <= '0;
						field_q      <= '0;
					end else if (last_q) begin
						// End of path: path state back to its reset values.
						seen_q    <= '0;
						emitted_q <= '0;
						pending_q <= '0;
						wr_ptr_q  <= '0;
						k_act_q   <= '0;
						started_q <= 1'b0;
					end
				end
				cmas_pkg::ST_SUM: begin
					if (issue_go) begin
						issue_q <= issue_q + 1'b1;
						slot_q  <= (slot_q == cmas_pkg::SLOT_W'(cmas_pkg::RING_DEPTH - 1))
							? '0 : slot_q + 1'b1;
					end
				end
				cmas_pkg::ST_DIV: begin
					if (div_rsp.done && !field_last) begin
						field_q <= field_q + 1'b1;
						slot_q  <= start_slot_q;
						issue_q <= '0;
					end
				end
				cmas_pkg::ST_OUT: begin
					if (out_free) begin
						pending_q <= pending_q - 1'b1;
						if (sm_q && (emitted_q != cmas_pkg::K_W'(cmas_pkg::MAX_HALF))) begin
							emitted_q <= emitted_q + 1'b1;
						end
					end
				end
				default: begin
					field_q <= '0;
				end
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			in_q[0] <= pos_x;
			in_q[1] <= pos_y;
			in_q[2] <= pos_z;
			in_q[3] <= heading;
			in_q[4] <= speed_long;
			in_q[5] <= accel;
			in_q[6] <= front_angle;
			in_q[7] <= yaw_rate;
			in_q[8] <= speed_lat;
			in_q[9] <= rear_angle;
			last_q  <= last_in;
		end

		// Window sum, restarted for every field.
		if ((state_q == cmas_pkg::ST_DECIDE)
			|| ((state_q == cmas_pkg::ST_DIV) && div_rsp.done)) begin
			acc_q <= '0;
		end else if (rd_valid_s1) begin
			acc_q <= acc_q + cmas_pkg::SUM_W'(signed'(ram_rdata));
		end

		if ((state_q == cmas_pkg::ST_DIV) && div_rsp.done) begin
			res_q[field_q] <= div_rsp.quotient;
		end

		if (out_load) begin
			out_q      <= res_q;
			out_last_q <= last_q && (pending_q == cmas_pkg::CNT_W'(1));
			out_sm_q   <= sm_q;
		end
	end

	// Ring memory: one word per field per slot.
	cmas_ram #(
		.WIDTH (cmas_pkg::DATA_W),
		.DEPTH (cmas_pkg::RAM_DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Shared divider for the means.
	cmas_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (div_cmd),
		.rsp    (div_rsp)
	);

	// Output channel.
	assign out_valid       = out_valid_q;
	assign avg_x           = out_q[0];
	assign avg_y           = out_q[1];
	assign avg_z           = out_q[2];
	assign avg_heading     = out_q[3];
	assign avg_speed_long  = out_q[4];
	assign avg_accel       = out_q[5];
	assign avg_front_angle = out_q[6];
	assign avg_yaw_rate    = out_q[7];
	assign avg_speed_lat   = out_q[8];
	assign avg_rear_angle  = out_q[9];
	assign last_out        = out_last_q;
	assign smoothed        = out_sm_q;

	// The ring never holds more unanswered points than it has slots.
	a_pending_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= cmas_pkg::CNT_W'(cmas_pkg::RING_DEPTH))
		else $error("pending count exceeds ring depth");

	// A divider result only comes back while the sequencer waits for it.
	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == cmas_pkg::ST_DIV))
		else $error("divider finished outside the divide state");

	// Finishing the final point leaves no path state behind.
	a_path_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == cmas_pkg::ST_DECIDE) && !dec_emit && last_q)
		|=> ((pending_q == '0) && (seen_q == '0) && !started_q))
		else $error("path state not cleared after the final point");

	// Smoothed results are counted only once the path is known to be smoothed.
	a_emitted_started: assert property (@(posedge clk) disable iff (!arst_n)
		!started_q |-> (emitted_q == '0))
		else $error("results counted on an unsmoothed path");

endmodule

// ===== src/cmas_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module cmas_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 330
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== src/cmas_div.sv =====
// Iterative signed divider: window sum over a small odd count, truncated toward zero.
// Depends on cmas_pkg.
module cmas_div (
	input  logic              clk,
	input  logic              arst_n,
	input  cmas_pkg::div_cmd_t cmd,
	output cmas_pkg::div_rsp_t rsp
);

	logic                             busy_q;
	logic                             done_q;
	logic [cmas_pkg::DIV_CNT_W-1:0]   step_q;
	logic [cmas_pkg::DIV_W-1:0]       q_q;
	logic [cmas_pkg::REM_W-1:0]       r_q;
	logic [cmas_pkg::CNT_W-1:0]       divisor_q;
	logic                             neg_q;
	logic [cmas_pkg::SUM_W-1:0]       mag;
	logic [cmas_pkg::DIV_W-1:0]       q_n;
	logic [cmas_pkg::REM_W-1:0]       r_n;
	logic                             last_step;

	// Magnitude of the dividend; the sign is put back on the quotient.
	always_comb begin
		if (cmd.dividend[cmas_pkg::SUM_W-1]) begin
			mag = cmas_pkg::SUM_W'(-cmd.dividend);
		end else begin
			mag = cmas_pkg::SUM_W'(cmd.dividend);
		end
	end

	// Several restoring steps per cycle; the remainder stays narrow.
	always_comb begin
		q_n = q_q;
		r_n = r_q;
		for (int i = 0; i < cmas_pkg::DIV_RADIX_BITS; i++) begin
			r_n = {r_n[cmas_pkg::REM_W-2:0], q_n[cmas_pkg::DIV_W-1]};
			q_n = {q_n[cmas_pkg::DIV_W-2:0], 1'b0};
			if (r_n >= cmas_pkg::REM_W'(divisor_q)) begin
				r_n    = r_n - cmas_pkg::REM_W'(divisor_q);
				q_n[0] = 1'b1;
			end
		end
	end

	assign last_step = (step_q == cmas_pkg::DIV_CNT_W'(cmas_pkg::DIV_CYCLES - 1));

	// Control: busy while the steps run, then a one-cycle done.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= busy_q && last_step;
			if (cmd.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (last_step) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			q_q       <= cmas_pkg::DIV_W'(mag);
			r_q       <= '0;
			neg_q     <= cmd.dividend[cmas_pkg::SUM_W-1];
			divisor_q <= cmd.divisor;
		end else if (busy_q) begin
			q_q <= q_n;
			r_q <= r_n;
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = neg_q ? cmas_pkg::word_t'(-q_q[cmas_pkg::DATA_W-1:0])
		: cmas_pkg::word_t'(q_q[cmas_pkg::DATA_W-1:0]);

endmodule

// ===== verif/tb_centered_moving_average_path_smoother_unit.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for centered_moving_average_path_smoother_unit.
// Drives paths of points and APB writes of the half width, and predicts every smoothed
// point with its own window model. Depends on cmas_pkg and the smoother RTL only.
module tb_centered_moving_average_path_smoother_unit;

	localparam int MAX_HALF    = cmas_pkg::MAX_HALF;
	localparam int FIELD_COUNT = cmas_pkg::FIELD_COUNT;
	localparam int DATA_W      = cmas_pkg::DATA_W;
	localparam int HW_RESET    = cmas_pkg::HW_RESET;
	localparam int RING_DEPTH  = cmas_pkg::RING_DEPTH;
	localparam int PADDR_W     = cmas_pkg::PADDR_W;

	localparam int QUIET_LIMIT   = 20000;
	localparam int LONG_HOLD     = 1500;
	localparam int SETTLE_CYCLES = 64;
	localparam int RANDOM_POINTS = 120;
	localparam int CNT_SAT       = 65535;
	localparam logic [PADDR_W-1:0] HALF_WINDOW_ADDR =
		PADDR_W'({cmas_pkg::REG_HALF_WINDOW, 2'b00});
	localparam logic [DATA_W-1:0] WORD_MAX = 32'h7FFF_FFFF;
	localparam logic [DATA_W-1:0] WORD_MIN = 32'h8000_0000;

	typedef enum {FILL_RANDOM, FILL_MAX, FILL_MIN, FILL_ALTERNATE} fill_t;

	// One path point as offered, and one smoothed point as returned.
	typedef struct packed {
		logic [FIELD_COUNT-1:0][DATA_W-1:0] val;
		logic                               last_flag;
	} path_point_t;

	typedef struct packed {
		logic [FIELD_COUNT-1:0][DATA_W-1:0] val;
		logic                               last_flag;
		logic                               smooth_flag;
	} smooth_point_t;

	// Window predictor and store of smoothed points still due.
	class path_scoreboard;
		longint        ring[RING_DEPTH][FIELD_COUNT];
		int unsigned   seen, emitted, pending, wr_ptr, k_now, half_width;
		bit            smoothing;
		smooth_point_t expected_q[$];
		int            errors, checked;
		string         field_name[FIELD_COUNT] = '{"avg_x", "avg_y", "avg_z", "avg_heading",
			"avg_speed_long", "avg_accel", "avg_front_angle", "avg_yaw_rate",
			"avg_speed_lat", "avg_rear_angle"};

		function new();
			half_width = HW_RESET;
			clear_path();
		endfunction

		function void clear_path();
			seen = 0;
			emitted = 0;
			pending = 0;
			wr_ptr = 0;
			k_now = 0;
			smoothing = 1'b0;
		endfunction

		function void set_half_width(int unsigned value);
			half_width = value & 5'h1F;
		endfunction

		// Append a due point at the end of the queue.
		function void queue_result(smooth_point_t r);
			expected_q.insert(expected_q.size(), r);
		endfunction

		// Mean over the window centred centre_back places before the newest point.
		function smooth_point_t window_mean(int unsigned centre_back, int unsigned reach,
			bit averaged);
			smooth_point_t r;
			longint        total;
			int unsigned   slot;
			for (int f = 0; f < FIELD_COUNT; f++) begin
				total = 0;
				for (int unsigned b = centre_back - reach; b <= centre_back + reach; b++) begin
					slot = (wr_ptr + RING_DEPTH - 1 - (b % RING_DEPTH)) % RING_DEPTH;
					total += ring[slot][f];
				end
				r.val[f] = 32'(total / longint'(2 * reach + 1));
			end
			r.last_flag = 1'b0;
			r.smooth_flag = averaged;
			return r;
		endfunction

		// An accepted point: store it and queue every result it releases.
		function void note_request(path_point_t p);
			smooth_point_t r;
			int unsigned   after, reach;
			int            made;
			made = 0;
			if (seen == 0) begin
				k_now = (half_width > MAX_HALF) ? MAX_HALF : half_width;
				smoothing = 1'b0;
			end
			for (int f = 0; f < FIELD_COUNT; f++)
				ring[wr_ptr][f] = longint'($signed(p.val[f]));
			wr_ptr = (wr_ptr + 1) % RING_DEPTH;
			if (seen < CNT_SAT)
				seen++;
			if (pending < RING_DEPTH)
				pending++;
			if (!smoothing && seen >= 2 * k_now + 1)
				smoothing = 1'b1;

			if (smoothing) begin
				while (pending > 0) begin
					after = pending - 1;
					reach = (emitted < k_now) ? emitted : k_now;
					if (after < reach) begin
						if (!p.last_flag)
							break;
						reach = after;
					end
					queue_result(window_mean(after, reach, 1'b1));
					made++;
					pending--;
					if (emitted < CNT_SAT)
						emitted++;
				end
			end else if (p.last_flag) begin
				// Path too short to smooth: held points leave unchanged.
				while (pending > 0) begin
					queue_result(window_mean(pending - 1, 0, 1'b0));
					made++;
					pending--;
				end
			end

			if (p.last_flag) begin
				if (made > 0) begin
					r = expected_q.pop_back();
					r.last_flag = 1'b1;
					queue_result(r);
				end
				clear_path();
			end
		endfunction

		function void check_result(smooth_point_t got);
			smooth_point_t want;
			checked++;
			if (expected_q.size() == 0) begin
				$error("Unexpected smoothed point: nothing was due");
				errors++;
				return;
			end
			want = expected_q.pop_front();
			for (int f = 0; f < FIELD_COUNT; f++) begin
				if (got.val[f] !== want.val[f]) begin
					$error("%s mismatch: expected %0d, got %0d", field_name[f],
						$signed(want.val[f]), $signed(got.val[f]));
					errors++;
				end
			end
			if (got.last_flag !== want.last_flag) begin
				$error("last_out mismatch: expected %0b, got %0b", want.last_flag, got.last_flag);
				errors++;
			end
			if (got.smooth_flag !== want.smooth_flag) begin
				$error("smoothed mismatch: expected %0b, got %0b", want.smooth_flag,
					got.smooth_flag);
				errors++;
			end
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 psel = 1'b0;
	logic                 penable = 1'b0;
	logic                 pwrite = 1'b0;
	logic [PADDR_W-1:0]   paddr = '0;
	logic [31:0]          pwdata = '0;
	logic [31:0]          prdata;
	logic                 pready;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic signed [31:0]   pos_x = '0, pos_y = '0, pos_z = '0, heading = '0;
	logic signed [31:0]   speed_long = '0, accel = '0, front_angle = '0, yaw_rate = '0;
	logic signed [31:0]   speed_lat = '0, rear_angle = '0;
	logic                 last_in = 1'b0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic signed [31:0]   avg_x, avg_y, avg_z, avg_heading, avg_speed_long, avg_accel;
	logic signed [31:0]   avg_front_angle, avg_yaw_rate, avg_speed_lat, avg_rear_angle;
	logic                 last_out, smoothed;

	path_scoreboard board = new();
	bit brisk = 1'b0;
	bit hold_request = 1'b0;
	int points_sent = 0, paths_sent = 0, settings_used = 0, long_holds = 0;
	int quiet_cycles = 0;

	centered_moving_average_path_smoother_unit i_dut (.*);

	always #4 clk = ~clk;

	// Accepted points feed the predictor.
	always @(posedge clk) begin: point_monitor
		path_point_t p;
		if (arst_n && in_valid && in_ready) begin
			p.val = {rear_angle, speed_lat, yaw_rate, front_angle, accel, speed_long, heading,
				pos_z, pos_y, pos_x};
			p.last_flag = last_in;
			board.note_request(p);
		end
	end

	// Accepted smoothed points are checked against the oldest one due.
	always @(posedge clk) begin: result_monitor
		smooth_point_t r;
		if (arst_n && out_valid && out_ready) begin
			r.val = {avg_rear_angle, avg_speed_lat, avg_yaw_rate, avg_front_angle, avg_accel,
				avg_speed_long, avg_heading, avg_z, avg_y, avg_x};
			r.last_flag = last_out;
			r.smooth_flag = smoothed;
			board.check_result(r);
		end
	end

	// Watchdog on cycles in which neither channel moves a request.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Watchdog: no request accepted for %0d cycles", QUIET_LIMIT);
				$display("FAILURE");
				$finish;
			end
		end
	end

	function automatic int draw_gap();
		return brisk ? 0 : $urandom_range(0, 9);
	endfunction

	function automatic logic [DATA_W-1:0] draw_word();
		case ($urandom_range(0, 5))
			0: return WORD_MAX;
			1: return WORD_MIN;
			2: return 32'($urandom_range(0, 16)) - 32'd8;
			default: return $urandom;
		endcase
	endfunction

	function automatic path_point_t make_point(fill_t fill, int idx, bit fin);
		path_point_t p;
		for (int f = 0; f < FIELD_COUNT; f++) begin
			case (fill)
				FILL_MAX: p.val[f] = WORD_MAX;
				FILL_MIN: p.val[f] = WORD_MIN;
				FILL_ALTERNATE: p.val[f] = ((idx + f) % 2) ? WORD_MAX : WORD_MIN;
				default: p.val[f] = draw_word();
			endcase
		end
		p.last_flag = fin;
		return p;
	endfunction

	// Receiver: random stall before each result, or one long hold on request.
	initial begin: result_sink
		int stall;
		wait (arst_n === 1'b1);
		forever begin
			stall = draw_gap();
			if (hold_request) begin
				hold_request = 1'b0;
				stall = LONG_HOLD;
				long_holds++;
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	// Offer one point after a random gap and hold it until accepted.
	task automatic offer_point(input path_point_t p);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		{rear_angle, speed_lat, yaw_rate, front_angle, accel, speed_long, heading, pos_z, pos_y,
			pos_x} <= p.val;
		last_in <= p.last_flag;
		do @(posedge clk); while (!in_ready);
		points_sent++;
	endtask

	// Stop offering, wait until every due point has come, then let the block settle.
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (board.expected_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write the half width, then read it back.
	task automatic write_half_width(input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= HALF_WINDOW_ADDR;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		board.set_half_width(value);
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== value) begin
			$error("half_window readback mismatch: expected %0d, got %0d", value, prdata);
			board.errors++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
		settings_used++;
	endtask

	// One path; after point pause_at the block drains and gets a new half width.
	task automatic send_path(input int len, input fill_t fill, input int pause_at);
		for (int i = 0; i < len; i++) begin
			offer_point(make_point(fill, i, i == len - 1));
			if (i == pause_at) begin
				settle();
				write_half_width($urandom_range(0, 31));
			end
		end
		paths_sent++;
	endtask

	initial begin: stimulus
		int    pick, k, n_paths, len, pause_at, phase, random_start, extra;
		fill_t fill;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset half width of five: single-point path and a short path pass through.
		send_path(1, FILL_MAX, -1);
		send_path(3, FILL_MIN, -1);
		settle();

		// Half width one: too short at two points, smoothed at three with extreme sums.
		write_half_width(1);
		send_path(2, FILL_ALTERNATE, -1);
		send_path(3, FILL_MAX, -1);
		send_path(3, FILL_MIN, -1);
		settle();

		// Half width zero: every point leaves at once, averaged over itself.
		write_half_width(0);
		send_path(3, FILL_RANDOM, -1);
		settle();

		// A write in the middle of a path only applies to the next path.
		write_half_width(2);
		send_path(6, FILL_ALTERNATE, 1);
		settle();

		// Half width above the maximum acts as the maximum.
		write_half_width(31);
		send_path(4, FILL_RANDOM, -1);
		settle();

		// Random phases: mostly small half widths and well-formed paths.
		random_start = points_sent;
		phase = 0;
		while (points_sent - random_start < RANDOM_POINTS) begin
			pick = (phase == 1) ? 0 : $urandom_range(0, 11);
			if (pick == 0)
				write_half_width($urandom_range(MAX_HALF, 31));
			else if (pick == 1)
				write_half_width($urandom_range(MAX_HALF + 1, 31));
			else
				write_half_width($urandom_range(0, 4));
			k = (board.half_width > MAX_HALF) ? MAX_HALF : board.half_width;
			brisk = ($urandom_range(0, 3) == 0);
			extra = 0;
			if (phase == 2 || $urandom_range(0, 9) == 0) begin
				hold_request = 1'b1;
				extra = 8;
			end
			n_paths = (k >= 8) ? 1 : $urandom_range(1, 3);
			repeat (n_paths) begin
				if (k > 0 && extra == 0 && $urandom_range(0, 4) == 0)
					len = $urandom_range(1, 2 * k);
				else
					len = 2 * k + 1 + extra + $urandom_range(0, (k >= 8) ? 2 : 6);
				pause_at = (len > 1 && $urandom_range(0, 7) == 0) ?
					$urandom_range(0, len - 2) : -1;
				fill = ($urandom_range(0, 9) == 0) ? FILL_ALTERNATE : FILL_RANDOM;
				send_path(len, fill, pause_at);
				k = (board.half_width > MAX_HALF) ? MAX_HALF : board.half_width;
			end
			settle();
			brisk = 1'b0;
			phase++;
		end

		$display("Sent %0d points in %0d paths over %0d half-width writes.", points_sent,
			paths_sent, settings_used);
		$display("Checked %0d smoothed points, with %0d long output holds.", board.checked,
			long_holds);
		if (board.errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ===== filelist.f =====
src/cmas_pkg.sv
src/cmas_ram.sv
src/cmas_div.sv
src/centered_moving_average_path_smoother_unit.sv
verif/tb_centered_moving_average_path_smoother_unit.sv
